>>> rtl/stm_pkg.sv
// Shared constants and types for the sliding trimmed mean block.
package stm_pkg;

  // Width of one time sample and of each mean.
  localparam int SAMPLE_W = 24;

  // Default window lengths.
  localparam int SHORT_WINDOW_DEF = 5;
  localparam int LONG_WINDOW_DEF  = 12;

  // Control from the sequencer to one window accumulator.
  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

endpackage

>>> rtl/stm_if.sv
// Valid/ready channel interfaces for the sample request and the mean result.
interface stm_in_if;
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::SAMPLE_W-1:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink   (input valid, input sample_time, output ready);
endinterface

interface stm_out_if;
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::SAMPLE_W-1:0] short_mean;
  logic                         short_valid;
  logic [stm_pkg::SAMPLE_W-1:0] long_mean;
  logic                         long_valid;

  modport source (output valid, output short_mean, output short_valid,
                  output long_mean, output long_valid, input ready);
  modport sink   (input valid, input short_mean, input short_valid,
                  input long_mean, input long_valid, output ready);
endinterface

>>> rtl/stm_hist_mem.sv
// Sample history memory: one write port, one read port, registered read data.
module stm_hist_mem #(
  parameter int DEPTH = stm_pkg::LONG_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [stm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [stm_pkg::SAMPLE_W-1:0] rd_data
);

  logic [stm_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Store the new sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/stm_accum.sv
// Window accumulator: running sum, minimum and maximum, and the rounded numerator.
module stm_accum #(
  parameter int WIN = stm_pkg::SHORT_WINDOW_DEF
) (
  input  logic                                         clk,
  input  stm_pkg::acc_ctrl_t                           ctrl,
  input  logic [stm_pkg::SAMPLE_W-1:0]                 data,
  output logic [stm_pkg::SAMPLE_W+$clog2(WIN):0]       num
);

  localparam int SUM_W = stm_pkg::SAMPLE_W + $clog2(WIN);
  localparam int NUM_W = SUM_W + 1;

  logic [SUM_W-1:0]             sum_r;
  logic [stm_pkg::SAMPLE_W-1:0] lo_r;
  logic [stm_pkg::SAMPLE_W-1:0] hi_r;
  logic [SUM_W-1:0]             trim;

  // Clear on a new request, then fold in each scanned sample that falls in the window
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end else if (ctrl.en) begin
      sum_r <= sum_r + SUM_W'(data);
      if (data < lo_r) lo_r <= data;
      if (data > hi_r) hi_r <= data;
    end
  end

  // Drop one minimum and one maximum; numerator is 2*sum + d for round-half-up
  assign trim = sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
  assign num  = {trim, 1'b0} + NUM_W'(WIN - 2);

endmodule

>>> rtl/stm_div.sv
// Divider by a fixed divisor: registered numerator, then one reciprocal multiply.
module stm_div #(
  parameter int NUM_W = stm_pkg::SAMPLE_W + $clog2(stm_pkg::LONG_WINDOW_DEF) + 1,
  parameter int DEN   = 2 * (stm_pkg::LONG_WINDOW_DEF - 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  // Reciprocal ceil(2^SHIFT / DEN) with SHIFT = NUM_W + ceil(log2 DEN) is exact
  // for every numerator below 2^NUM_W and fits in NUM_W + 1 bits
  localparam int DEN_W  = $clog2(DEN);
  localparam int SHIFT  = NUM_W + DEN_W;
  localparam int MUL_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + MUL_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DEN - 1)) / 64'(DEN);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  quo_r;
  logic              busy_r;
  logic [PROD_W-1:0] prod;

  assign prod = {{MUL_W{1'b0}}, num_r} * {{NUM_W{1'b0}}, RECIP};

  // Hold busy for the one multiply cycle after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  // Capture the numerator, then scale by the reciprocal and drop the fraction
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
    end
    if (busy_r) begin
      quo_r <= NUM_W'(prod >> SHIFT);
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

>>> rtl/sliding_trimmed_mean.sv
// Sliding trimmed mean top level: history memory, window scan and two dividers.
// Steps: the accepting edge starts a history scan, newest to oldest, then divider start,
//   divide and output load, which raises out valid. A request is accepted only in idle,
//   after the last result is loaded; the scan takes most of that time, and an unclaimed
//   result stalls the next one in the final state. Reset (rst_n low, synchronous) clears
//   the write slot, sample count and handshake state; the history is not cleared.
module sliding_trimmed_mean #(
  parameter int SHORT_WINDOW = stm_pkg::SHORT_WINDOW_DEF,
  parameter int LONG_WINDOW  = stm_pkg::LONG_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  stm_in_if.sink    in_ch,
  stm_out_if.source out_ch
);

  localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int S_NUM_W    = stm_pkg::SAMPLE_W + $clog2(SHORT_WINDOW) + 1;
  localparam int L_NUM_W    = stm_pkg::SAMPLE_W + $clog2(LONG_WINDOW) + 1;
  localparam int W          = stm_pkg::SAMPLE_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DSTART, S_DIV, S_FIN} state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  wslot_r;
  logic [CNT_W-1:0]   seen_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic [CNT_W-1:0]   issue_r;
  logic [CNT_W-1:0]   idx_r;
  logic               vld_r;
  logic               out_valid_r;
  logic [W-1:0]       short_mean_r;
  logic               short_valid_r;
  logic [W-1:0]       long_mean_r;
  logic               long_valid_r;

  logic               accept;
  logic               rd_en;
  logic [W-1:0]       rd_data;
  stm_pkg::acc_ctrl_t s_ctrl;
  stm_pkg::acc_ctrl_t l_ctrl;
  logic [S_NUM_W-1:0] s_num;
  logic [L_NUM_W-1:0] l_num;
  logic [S_NUM_W-1:0] s_quo;
  logic [L_NUM_W-1:0] l_quo;
  logic               s_busy;
  logic               l_busy;
  logic               div_start;
  logic               s_full;
  logic               l_full;
  logic               out_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_en       = (state_r == S_SCAN) && (issue_r < CNT_W'(HIST_DEPTH));
  assign div_start   = (state_r == S_DSTART);
  assign s_full      = seen_r >= CNT_W'(SHORT_WINDOW);
  assign l_full      = seen_r >= CNT_W'(LONG_WINDOW);
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Accumulate only the newest samples that fall in each window
  assign s_ctrl.clear = accept;
  assign s_ctrl.en    = vld_r && (idx_r < CNT_W'(SHORT_WINDOW));
  assign l_ctrl.clear = accept;
  assign l_ctrl.en    = vld_r && (idx_r < CNT_W'(LONG_WINDOW));

  stm_hist_mem #(.DEPTH(HIST_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wslot_r),
    .wr_data (in_ch.sample_time),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  stm_accum #(.WIN(SHORT_WINDOW)) u_s_acc (
    .clk (clk), .ctrl (s_ctrl), .data (rd_data), .num (s_num)
  );

  stm_accum #(.WIN(LONG_WINDOW)) u_l_acc (
    .clk (clk), .ctrl (l_ctrl), .data (rd_data), .num (l_num)
  );

  stm_div #(.NUM_W(S_NUM_W), .DEN(2 * (SHORT_WINDOW - 2))) u_s_div (
    .clk (clk), .rst_n (rst_n), .start (div_start), .num (s_num),
    .busy (s_busy), .quo (s_quo)
  );

  stm_div #(.NUM_W(L_NUM_W), .DEN(2 * (LONG_WINDOW - 2))) u_l_div (
    .clk (clk), .rst_n (rst_n), .start (div_start), .num (l_num),
    .busy (l_busy), .quo (l_quo)
  );

  // Sequencer: store, scan newest to oldest, divide, present the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wslot_r     <= '0;
      seen_r      <= '0;
      issue_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result when loaded, drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            rd_addr_r <= wslot_r;
            wslot_r   <= (wslot_r == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
            if (seen_r < CNT_W'(HIST_DEPTH)) seen_r <= seen_r + 1'b1;
            issue_r   <= '0;
            vld_r     <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          vld_r <= rd_en;
          idx_r <= issue_r;
          if (rd_en) begin
            issue_r   <= issue_r + 1'b1;
            rd_addr_r <= (rd_addr_r == '0) ? ADDR_W'(HIST_DEPTH - 1) : rd_addr_r - 1'b1;
          end
          if (vld_r && idx_r == CNT_W'(HIST_DEPTH - 1)) state_r <= S_DSTART;
        end
        S_DSTART: begin
          vld_r   <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!s_busy && !l_busy) state_r <= S_FIN;
        end
        S_FIN: begin
          // Hold until the output register is free
          if (out_load) begin
            short_mean_r  <= s_full ? s_quo[W-1:0] : '0;
            short_valid_r <= s_full;
            long_mean_r   <= l_full ? l_quo[W-1:0] : '0;
            long_valid_r  <= l_full;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.short_mean  = short_mean_r;
  assign out_ch.short_valid = short_valid_r;
  assign out_ch.long_mean   = long_mean_r;
  assign out_ch.long_valid  = long_valid_r;

  // Dividers must be idle when a new division starts
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DSTART |-> !s_busy && !l_busy)
    else $error("divider restarted while busy");

  // Sample count saturates at the history depth
  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(HIST_DEPTH))
    else $error("sample count past history depth");

  // A new result appears only out of the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside final state");

  // The scan never issues more reads than the history holds
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= CNT_W'(HIST_DEPTH))
    else $error("scan ran past history depth");

endmodule

>>> test/sliding_trimmed_mean_tb.sv
// Self-checking testbench for the sliding trimmed mean block: directed table, then random samples.
module sliding_trimmed_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHORT_WIN  = stm_pkg::SHORT_WINDOW_DEF;
  localparam int LONG_WIN   = stm_pkg::LONG_WINDOW_DEF;
  localparam int HIST_DEPTH = (SHORT_WIN > LONG_WIN) ? SHORT_WIN : LONG_WIN;
  localparam int N_RANDOM    = 1280;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [stm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef logic [stm_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t short_mean;
    logic    short_valid;
    sample_t long_mean;
    logic    long_valid;
  } mean_res_t;

  typedef struct packed {
    sample_t   smp;
    logic      typed;
    mean_res_t res;
  } stim_row_t;

  localparam mean_res_t NOT_YET = '{24'd0, 1'b0, 24'd0, 1'b0};
  localparam int N_DIR = 24;

  // Directed requests; typed rows carry a result that can be read off directly
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{24'hFFFFFF, 1'b1, NOT_YET},
    '{24'hFFFFFF, 1'b1, NOT_YET},
    '{24'hFFFFFF, 1'b1, NOT_YET},
    '{24'hFFFFFF, 1'b1, NOT_YET},
    '{24'hFFFFFF, 1'b1, '{24'hFFFFFF, 1'b1, 24'd0, 1'b0}},
    '{24'd0,      1'b0, NOT_YET},
    '{24'd0,      1'b0, NOT_YET},
    '{24'd0,      1'b0, NOT_YET},
    '{24'd0,      1'b0, NOT_YET},
    '{24'd0,      1'b1, '{24'd0, 1'b1, 24'd0, 1'b0}},
    '{24'd0,      1'b0, NOT_YET},
    '{24'hFFFFFF, 1'b0, NOT_YET},
    '{24'd1,      1'b0, NOT_YET},
    '{24'd2,      1'b0, NOT_YET},
    '{24'd2,      1'b0, NOT_YET},
    '{24'd1,      1'b0, NOT_YET},
    '{24'd3,      1'b0, NOT_YET},
    '{24'd7,      1'b0, NOT_YET},
    '{24'd7,      1'b0, NOT_YET},
    '{24'd7,      1'b0, NOT_YET},
    '{24'd7,      1'b0, NOT_YET},
    '{24'd7,      1'b0, NOT_YET},
    '{24'hFFFFFF, 1'b0, NOT_YET},
    '{24'd0,      1'b0, NOT_YET}
  };

  logic clk;
  logic rst_n;

  stm_in_if  in_ch();
  stm_out_if out_ch();

  sliding_trimmed_mean i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  sample_t   hist [HIST_DEPTH];
  int        wr_slot;
  int        seen_cnt;
  mean_res_t mean_q [$];
  int        err_cnt;
  bit        calm;
  sample_t   prev_smp;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Trimmed mean over the newest win entries, rounded half up
  function automatic sample_t trim_mean(int newest, int win);
    longint unsigned sum;
    longint unsigned d;
    sample_t lo;
    sample_t hi;
    sample_t v;
    int pos;
    sum = 0;
    lo  = SAMPLE_MAX;
    hi  = '0;
    pos = newest;
    for (int k = 0; k < win; k++) begin
      v = hist[pos];
      sum += v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      pos = (pos == 0) ? HIST_DEPTH - 1 : pos - 1;
    end
    sum = sum - lo - hi;
    d = win - 2;
    return sample_t'((2 * sum + d) / (2 * d));
  endfunction

  // Store one sample and work out both means
  function automatic mean_res_t predict_means(sample_t smp);
    mean_res_t r;
    int newest;
    newest = wr_slot;
    hist[newest] = smp;
    wr_slot = (newest + 1 >= HIST_DEPTH) ? 0 : newest + 1;
    if (seen_cnt < HIST_DEPTH) seen_cnt++;
    r = NOT_YET;
    if (seen_cnt >= SHORT_WIN) begin
      r.short_mean  = trim_mean(newest, SHORT_WIN);
      r.short_valid = 1'b1;
    end
    if (seen_cnt >= LONG_WIN) begin
      r.long_mean  = trim_mean(newest, LONG_WIN);
      r.long_valid = 1'b1;
    end
    return r;
  endfunction

  // Random sample: full range, extremes, small values, repeats and clusters
  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = sample_t'($urandom());
      4:          s = $urandom_range(1) ? SAMPLE_MAX : '0;
      5, 6:       s = sample_t'($urandom_range(50));
      7:          s = prev_smp;
      default:    s = prev_smp + sample_t'($urandom_range(3));
    endcase
    prev_smp = s;
    return s;
  endfunction

  // Issue one request, hold it until accepted, then record the expected means
  task automatic send_sample(input sample_t smp, input logic typed, input mean_res_t typed_res);
    int gap;
    mean_res_t r;
    gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 50) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_time <= smp;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_means(smp);
    mean_q.insert(mean_q.size(), typed ? typed_res : r);
  endtask

  // Hold off new requests until every pending result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.sample_time = '0;
    rst_n    = 1'b0;
    wr_slot  = 0;
    seen_cnt = 0;
    err_cnt  = 0;
    calm     = 1'b0;
    prev_smp = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_sample(DIR_TAB[i].smp, DIR_TAB[i].typed, DIR_TAB[i].res);
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 500 && i < 700);
      if (i % 300 == 299) drain_results();
      send_sample(pick_sample(), 1'b0, NOT_YET);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (mean_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && mean_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Drive result ready with random back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  function automatic void check_field(string name, sample_t exp_v, sample_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mean_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mean_q.size() == 0) begin
        $display("%0t: result with no request pending, got short %0d/%0b long %0d/%0b",
                 $time, out_ch.short_mean, out_ch.short_valid,
                 out_ch.long_mean, out_ch.long_valid);
        err_cnt++;
      end else begin
        exp_r = mean_q.pop_front();
        check_field("short_mean", exp_r.short_mean, out_ch.short_mean);
        check_field("short_valid", sample_t'(exp_r.short_valid), sample_t'(out_ch.short_valid));
        check_field("long_mean", exp_r.long_mean, out_ch.long_mean);
        check_field("long_valid", sample_t'(exp_r.long_valid), sample_t'(out_ch.long_valid));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

endmodule

>>> files.f
rtl/stm_pkg.sv
rtl/stm_if.sv
rtl/stm_hist_mem.sv
rtl/stm_accum.sv
rtl/stm_div.sv
rtl/sliding_trimmed_mean.sv
test/sliding_trimmed_mean_tb.sv
